/* hw/rtl/earm_pkg.sv */
// Shared types, constants and the arctangent table of the elliptic arc region test.
package earm_pkg;

  // Default fraction width of the point and center coordinates
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Vectoring steps and working widths of the angle pipeline
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned NORM_BITS    = 30;
  localparam int unsigned XW           = 33;
  localparam int unsigned ZW           = 33;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VSCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RING_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END        = 3'd6;

  // Angle codes in units of 2^-16 turn, turn fractions in units of 2^-32 turn
  localparam logic [16:0] CODE_UP    = 17'd16384;
  localparam logic [16:0] CODE_DOWN  = 17'd49152;
  localparam logic [32:0] TURN_FULL  = 33'h1_0000_0000;
  localparam logic [32:0] TURN_HALF  = 33'h0_8000_0000;
  localparam logic [ZW-1:0] PHI_MAX  = ZW'((64'd1 << NORM_BITS) - 64'd1);

  // Flags that ride along with a word through the pipeline
  typedef struct packed {
    logic ring_ok;
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
    logic last;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10679838;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      24: r = 30'd41;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      28: r = 30'd3;
      29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/earm_cordic.sv */
// Pipelined CORDIC vectoring unit: one rotation step per register stage.
module earm_cordic #(
  parameter int unsigned STEPS = earm_pkg::CORDIC_STEPS
) (
  input  logic                              clk_i,
  input  logic [STEPS-1:0]                  en_i,
  input  logic signed [earm_pkg::XW-1:0]    x_i,
  input  logic signed [earm_pkg::XW-1:0]    y_i,
  input  earm_pkg::side_t                   side_i,
  output logic signed [earm_pkg::ZW-1:0]    z_o,
  output earm_pkg::side_t                   side_o
);
  import earm_pkg::*;

  logic signed [XW-1:0] x_in [STEPS];
  logic signed [XW-1:0] y_in [STEPS];
  logic signed [ZW-1:0] z_in [STEPS];
  side_t                s_in [STEPS];
  logic signed [XW-1:0] x_q  [STEPS];
  logic signed [XW-1:0] y_q  [STEPS];
  logic signed [ZW-1:0] z_q  [STEPS];
  side_t                s_q  [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic signed [XW-1:0] x_d, y_d;
    logic signed [ZW-1:0] z_d;
    logic signed [ZW-1:0] ang;

    // Take the previous stage, or the unit input at the first step
    if (g == 0) begin : g_first
      assign x_in[g] = x_i;
      assign y_in[g] = y_i;
      assign z_in[g] = '0;
      assign s_in[g] = side_i;
    end else begin : g_next
      assign x_in[g] = x_q[g-1];
      assign y_in[g] = y_q[g-1];
      assign z_in[g] = z_q[g-1];
      assign s_in[g] = s_q[g-1];
    end

    assign ang = ZW'(atan_turn(g));

    // Rotate toward the x axis and accumulate the angle
    always_comb begin
      if (!y_in[g][XW-1]) begin
        x_d = x_in[g] + (y_in[g] >>> g);
        y_d = y_in[g] - (x_in[g] >>> g);
        z_d = z_in[g] + ang;
      end else begin
        x_d = x_in[g] - (y_in[g] >>> g);
        y_d = y_in[g] + (x_in[g] >>> g);
        z_d = z_in[g] - ang;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g]) begin
        x_q[g] <= x_d;
        y_q[g] <= y_d;
        z_q[g] <= z_d;
        s_q[g] <= s_in[g];
      end
    end
  end

  assign z_o    = z_q[STEPS-1];
  assign side_o = s_q[STEPS-1];

endmodule

/* hw/rtl/elliptic_arc_region_membership_core.sv */
// Top level of the elliptic arc region membership test pipeline.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   point_re_i, point_im_i, last_point_i
//   output    out        out_valid_o / out_stall_i inside_flag_o, last_point_out_o
//   config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One word enters per cycle unless the input stalls; the pipeline has 7 front stages
// for offsets, products and the ring compare, 30 CORDIC stages and one output stage.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output holds its word; empty stages upstream keep filling, and the input
// stalls only when every stage holds a word.
module elliptic_arc_region_membership_core #(
  parameter int unsigned FRAC_BITS = earm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [earm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [earm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [31:0]                point_re_i,
  input  logic signed [31:0]                point_im_i,
  input  logic                              last_point_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              inside_flag_o,
  output logic                              last_point_out_o
);
  import earm_pkg::*;

  localparam int unsigned FRONT = 7;
  localparam int unsigned NSTG  = FRONT + CORDIC_STEPS + 1;
  localparam int unsigned AYW   = 33 + FRAC_BITS;

  // Configuration registers
  logic [31:0] center_re_q, center_im_q;
  logic [30:0] radius_q, vscale_q, ring_width_q;
  logic [16:0] start_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q  <= '0;
      center_im_q  <= '0;
      radius_q     <= 31'd65536;
      vscale_q     <= 31'd65536;
      ring_width_q <= 31'd6554;
      start_q      <= '0;
      end_q        <= 17'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_RE:  center_re_q  <= cfg_data_i;
        REG_CENTER_IM:  center_im_q  <= cfg_data_i;
        REG_RADIUS:     radius_q     <= cfg_data_i[30:0];
        REG_VSCALE:     vscale_q     <= cfg_data_i[30:0];
        REG_RING_WIDTH: ring_width_q <= cfg_data_i[30:0];
        REG_START:      start_q      <= cfg_data_i[16:0];
        REG_END:        end_q        <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves on
  logic [NSTG-1:0] v_q, v_d;
  logic [NSTG:0]   en;

  assign en[NSTG] = !out_stall_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSTG; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= v_d;
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NSTG-1];

  // Stage 1: offsets from the center
  logic [32:0] s1_dx_q, s1_dy_q;
  logic        s1_last_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_dx_q   <= {point_re_i[31], point_re_i} - {center_re_q[31], center_re_q};
      s1_dy_q   <= {point_im_i[31], point_im_i} - {center_im_q[31], center_im_q};
      s1_last_q <= last_point_i;
    end
  end

  // Stage 2: magnitudes, quadrant flags and ring diameters
  logic [32:0] s2_ux_q, s2_uy_q, s2_ro2_q, s2_ri2_q;
  side_t       s2_side_q;
  logic [32:0] r2, wd;

  assign r2 = {1'b0, radius_q, 1'b0};
  assign wd = {2'b0, ring_width_q};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_ux_q           <= s1_dx_q[32] ? (~s1_dx_q + 33'd1) : s1_dx_q;
      s2_uy_q           <= s1_dy_q[32] ? (~s1_dy_q + 33'd1) : s1_dy_q;
      s2_ro2_q          <= r2 + wd;
      s2_ri2_q          <= (r2 >= wd) ? (r2 - wd) : (wd - r2);
      s2_side_q.ring_ok <= 1'b0;
      s2_side_q.dx_zero <= (s1_dx_q == '0);
      s2_side_q.dy_zero <= (s1_dy_q == '0);
      s2_side_q.dx_neg  <= s1_dx_q[32];
      s2_side_q.dy_neg  <= s1_dy_q[32];
      s2_side_q.last    <= s1_last_q;
    end
  end

  // Stage 3: scale by vscale, square the vertical offset
  logic [63:0]    s3_ax_q, s3_bo_q, s3_bi_q;
  logic [65:0]    s3_uy2_q;
  logic [AYW-1:0] s3_ay_q;
  side_t          s3_side_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_ax_q   <= 64'(s2_ux_q) * 64'(vscale_q);
      s3_bo_q   <= 64'(s2_ro2_q) * 64'(vscale_q);
      s3_bi_q   <= 64'(s2_ri2_q) * 64'(vscale_q);
      s3_uy2_q  <= 66'(s2_uy_q) * 66'(s2_uy_q);
      s3_ay_q   <= {s2_uy_q, {FRAC_BITS{1'b0}}};
      s3_side_q <= s2_side_q;
    end
  end

  // Stage 4: partial products of the three squares, larger CORDIC operand
  logic [63:0] sq_src [3];
  logic [63:0] s4_ll_q [3];
  logic [63:0] s4_lh_q [3];
  logic [63:0] s4_hh_q [3];
  logic [65:0] s4_uy2_q;
  logic [63:0] s4_ax_q, s4_ay_q, s4_m_q;
  side_t       s4_side_q;
  logic [63:0] ay64;

  assign sq_src[0] = s3_ax_q;
  assign sq_src[1] = s3_bo_q;
  assign sq_src[2] = s3_bi_q;
  assign ay64      = 64'(s3_ay_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        s4_ll_q[j] <= 64'(sq_src[j][31:0]) * 64'(sq_src[j][31:0]);
        s4_lh_q[j] <= 64'(sq_src[j][31:0]) * 64'(sq_src[j][63:32]);
        s4_hh_q[j] <= 64'(sq_src[j][63:32]) * 64'(sq_src[j][63:32]);
      end
      s4_uy2_q  <= s3_uy2_q;
      s4_ax_q   <= s3_ax_q;
      s4_ay_q   <= ay64;
      s4_m_q    <= (s3_ax_q > ay64) ? s3_ax_q : ay64;
      s4_side_q <= s3_side_q;
    end
  end

  // Bit length by halving search over the window
  function automatic logic [6:0] bit_len64(logic [63:0] m);
    logic [63:0] w;
    logic [6:0]  n;
    w = m;
    n = '0;
    for (int i = 0; i < 6; i++) begin
      if ((w >> (32 >> i)) != '0) begin
        n = n + 7'(32 >> i);
        w = w >> (32 >> i);
      end
    end
    n = n + 7'(w[0]);
    return n;
  endfunction

  // Stage 5: assemble squares, find the normalizing shift
  logic [127:0] sq_d [3];
  logic [127:0] s5_axsq_q, s5_bosq_q, s5_bisq_q, s5_py_q;
  logic [63:0]  s5_ax_q, s5_ay_q;
  logic [5:0]   s5_sh_q;
  side_t        s5_side_q;
  logic [6:0]   blen;

  for (genvar j = 0; j < 3; j++) begin : g_sq
    assign sq_d[j] = (128'(s4_hh_q[j]) << 64) + (128'(s4_lh_q[j]) << 33)
                   + 128'(s4_ll_q[j]);
  end

  assign blen = bit_len64(s4_m_q);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_axsq_q <= sq_d[0];
      s5_bosq_q <= sq_d[1];
      s5_bisq_q <= sq_d[2];
      s5_py_q   <= 128'(s4_uy2_q) << (2 * FRAC_BITS);
      s5_sh_q   <= (blen > 7'(NORM_BITS)) ? 6'(blen - 7'(NORM_BITS)) : 6'd0;
      s5_ax_q   <= s4_ax_q;
      s5_ay_q   <= s4_ay_q;
      s5_side_q <= s4_side_q;
    end
  end

  // Stage 6: scaled distance sum, normalized CORDIC operands
  logic [129:0]         s6_sum_q;
  logic [127:0]         s6_bosq_q, s6_bisq_q;
  logic [NORM_BITS-1:0] s6_x_q, s6_y_q;
  side_t                s6_side_q;
  logic [63:0]          ax_sh, ay_sh;

  assign ax_sh = s5_ax_q >> s5_sh_q;
  assign ay_sh = s5_ay_q >> s5_sh_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_sum_q  <= (130'(s5_axsq_q) + 130'(s5_py_q)) << 2;
      s6_bosq_q <= s5_bosq_q;
      s6_bisq_q <= s5_bisq_q;
      s6_x_q    <= ax_sh[NORM_BITS-1:0];
      s6_y_q    <= ay_sh[NORM_BITS-1:0];
      s6_side_q <= s5_side_q;
    end
  end

  // Stage 7: ring compare against both ellipses
  logic signed [XW-1:0] s7_x_q, s7_y_q;
  side_t                s7_side_q;
  side_t                s6_side_ring;

  always_comb begin
    s6_side_ring         = s6_side_q;
    s6_side_ring.ring_ok = (s6_sum_q < 130'(s6_bosq_q)) && (s6_sum_q > 130'(s6_bisq_q));
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_x_q    <= XW'(s6_x_q);
      s7_y_q    <= XW'(s6_y_q);
      s7_side_q <= s6_side_ring;
    end
  end

  // Angle of the first quadrant operands
  logic signed [ZW-1:0] cz;
  side_t                cside;

  earm_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en[FRONT+CORDIC_STEPS-1:FRONT]),
    .x_i    (s7_x_q),
    .y_i    (s7_y_q),
    .side_i (s7_side_q),
    .z_o    (cz),
    .side_o (cside)
  );

  // Output stage: clamp, quadrant fold, arc compare
  logic [32:0] phi, turn;
  logic [16:0] code;
  logic        inside_d;
  logic        inside_q, last_q;

  always_comb begin
    if (cz[ZW-1])          phi = '0;
    else if (cz > PHI_MAX) phi = 33'(PHI_MAX);
    else                   phi = 33'(cz);

    case ({cside.dx_neg, cside.dy_neg})
      2'b00:   turn = phi;
      2'b01:   turn = TURN_FULL - ((phi == '0) ? 33'd1 : phi);
      2'b10:   turn = TURN_HALF - phi;
      default: turn = TURN_HALF + phi;
    endcase

    if (cside.dx_zero) code = cside.dy_neg ? CODE_DOWN : CODE_UP;
    else               code = turn[32:16];

    inside_d = cside.ring_ok && !(cside.dx_zero && cside.dy_zero)
            && (code >= start_q) && (code <= end_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      inside_q <= inside_d;
      last_q   <= cside.last;
    end
  end

  assign inside_flag_o    = inside_q;
  assign last_point_out_o = last_q;

  // Checks
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted word did not enter the first stage");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled while a stage is empty");

  a_tail_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NSTG-1] |-> !in_stall_o)
    else $error("input stalled with an empty output stage");

endmodule
